### rtl/qrm_pkg.sv
// Shared widths and pipeline payload types for the quaternion to rotation matrix block.
// No dependencies; every rtl file refers to it by scoped names.
package qrm_pkg;

    localparam int COMP_W   = 16;             // quaternion component width
    localparam int FRAC_W   = 14;             // fraction bits of a matrix element
    localparam int ELEM_W   = 16;             // width of a matrix element on the port
    localparam int NUM_ELEM = 9;
    localparam int PROD_W   = 2 * COMP_W;     // signed product of two components
    localparam int DEN_W    = 2 * COMP_W + 1; // squared norm and numerator magnitudes
    localparam int REM_W    = DEN_W + 1;      // partial remainder after the shift
    localparam int QUO_W    = FRAC_W + 1;     // one integer bit and the fraction bits
    localparam int IN_W     = 4 * COMP_W;
    localparam int OUT_W    = NUM_ELEM * ELEM_W;

    localparam logic [QUO_W-1:0]  QUO_ONE  = QUO_W'(1) << FRAC_W;
    localparam logic [ELEM_W-1:0] ELEM_ONE = ELEM_W'(1) << FRAC_W;

    typedef struct packed {
        logic signed [PROD_W-1:0] ww;
        logic signed [PROD_W-1:0] xx;
        logic signed [PROD_W-1:0] yy;
        logic signed [PROD_W-1:0] zz;
        logic signed [PROD_W-1:0] xy;
        logic signed [PROD_W-1:0] xz;
        logic signed [PROD_W-1:0] yz;
        logic signed [PROD_W-1:0] wx;
        logic signed [PROD_W-1:0] wy;
        logic signed [PROD_W-1:0] wz;
    } prod_t;

    typedef struct packed {
        logic [DEN_W-1:0]                  den;
        logic [NUM_ELEM-1:0][REM_W-1:0]    rem;
        logic [NUM_ELEM-1:0][QUO_W-1:0]    quo;
        logic [NUM_ELEM-1:0]               neg;
        logic                              degen;
    } div_t;

endpackage

### rtl/qrm_products.sv
// First pipeline stage: the ten component products, one multiplier each.
// Depends on qrm_pkg.
module qrm_products (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [qrm_pkg::IN_W-1:0] in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output qrm_pkg::prod_t           out_data
);

    logic signed [qrm_pkg::COMP_W-1:0] w, x, y, z;
    logic           valid_reg;
    qrm_pkg::prod_t data_reg, data_next;

    assign w = in_data[0*qrm_pkg::COMP_W +: qrm_pkg::COMP_W];
    assign x = in_data[1*qrm_pkg::COMP_W +: qrm_pkg::COMP_W];
    assign y = in_data[2*qrm_pkg::COMP_W +: qrm_pkg::COMP_W];
    assign z = in_data[3*qrm_pkg::COMP_W +: qrm_pkg::COMP_W];

    always_comb
    begin
        data_next.ww = qrm_pkg::PROD_W'(w * w);
        data_next.xx = qrm_pkg::PROD_W'(x * x);
        data_next.yy = qrm_pkg::PROD_W'(y * y);
        data_next.zz = qrm_pkg::PROD_W'(z * z);
        data_next.xy = qrm_pkg::PROD_W'(x * y);
        data_next.xz = qrm_pkg::PROD_W'(x * z);
        data_next.yz = qrm_pkg::PROD_W'(y * z);
        data_next.wx = qrm_pkg::PROD_W'(w * x);
        data_next.wy = qrm_pkg::PROD_W'(w * y);
        data_next.wz = qrm_pkg::PROD_W'(w * z);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

### rtl/qrm_numer.sv
// Second pipeline stage: squared norm and the nine numerators in sign-magnitude form.
// Depends on qrm_pkg.
module qrm_numer (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  qrm_pkg::prod_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output qrm_pkg::div_t  out_data
);

    localparam int DW = qrm_pkg::DEN_W;
    localparam int RW = qrm_pkg::REM_W;

    logic          valid_reg;
    qrm_pkg::div_t data_reg, data_next;

    // Squares are never negative, so their low bits zero-extend as unsigned.
    function automatic logic [DW-1:0] usum(input logic signed [qrm_pkg::PROD_W-1:0] a,
                                           input logic signed [qrm_pkg::PROD_W-1:0] b);
        return {1'b0, a} + {1'b0, b};
    endfunction

    // Off-diagonal numerator: magnitude of 2*(p + q) and its sign.
    function automatic logic [RW:0] offd(input logic signed [qrm_pkg::PROD_W-1:0] p,
                                         input logic signed [qrm_pkg::PROD_W-1:0] q);
        logic signed [DW-1:0] s;
        logic [DW-1:0]        mag;
        s   = DW'(p) + DW'(q);
        mag = s[DW-1] ? DW'(-s) : DW'(s);
        return {s[DW-1], RW'({mag[DW-2:0], 1'b0})};
    endfunction

    // Diagonal numerator: magnitude of pos - neg and its sign.
    function automatic logic [RW:0] dia(input logic [DW-1:0] pos, input logic [DW-1:0] ng);
        logic signed [DW-1:0] d;
        logic [DW-1:0]        mag;
        d   = $signed(pos - ng);
        mag = d[DW-1] ? DW'(-d) : DW'(d);
        return {d[DW-1], RW'(mag)};
    endfunction

    always_comb
    begin
        logic [DW-1:0] s_wx, s_yz, s_wy, s_xz, s_wz, s_xy;
        logic [RW:0]   e [qrm_pkg::NUM_ELEM];
        s_wx = usum(in_data.ww, in_data.xx);
        s_yz = usum(in_data.yy, in_data.zz);
        s_wy = usum(in_data.ww, in_data.yy);
        s_xz = usum(in_data.xx, in_data.zz);
        s_wz = usum(in_data.ww, in_data.zz);
        s_xy = usum(in_data.xx, in_data.yy);
        e[0] = dia(s_wx, s_yz);
        e[1] = offd(in_data.xy, -in_data.wz);
        e[2] = offd(in_data.xz, in_data.wy);
        e[3] = offd(in_data.xy, in_data.wz);
        e[4] = dia(s_wy, s_xz);
        e[5] = offd(in_data.yz, -in_data.wx);
        e[6] = offd(in_data.xz, -in_data.wy);
        e[7] = offd(in_data.yz, in_data.wx);
        e[8] = dia(s_wz, s_xy);
        data_next.den   = s_wx + s_yz;
        data_next.degen = (s_wx + s_yz) == '0;
        for (int i = 0; i < qrm_pkg::NUM_ELEM; i++)
        begin
            data_next.rem[i] = e[i][RW-1:0];
            data_next.neg[i] = e[i][RW];
            data_next.quo[i] = '0;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

### rtl/qrm_div_step.sv
// One restoring-division stage: one quotient bit for each of the nine elements.
// Depends on qrm_pkg.
module qrm_div_step (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  qrm_pkg::div_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output qrm_pkg::div_t out_data
);

    logic          valid_reg;
    qrm_pkg::div_t data_reg, data_next;

    // Compare and subtract, then shift the remainder up for the next bit.
    always_comb
    begin
        logic [qrm_pkg::REM_W-1:0] den_x, r;
        logic                      bit_q;
        data_next = in_data;
        den_x     = qrm_pkg::REM_W'(in_data.den);
        for (int i = 0; i < qrm_pkg::NUM_ELEM; i++)
        begin
            bit_q = in_data.rem[i] >= den_x;
            r     = bit_q ? in_data.rem[i] - den_x : in_data.rem[i];
            data_next.rem[i] = {r[qrm_pkg::REM_W-2:0], 1'b0};
            data_next.quo[i] = {in_data.quo[i][qrm_pkg::QUO_W-2:0], bit_q};
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

### rtl/qrm_output.sv
// Last stage: saturation, sign and the identity for a zero quaternion, into the output register.
// Depends on qrm_pkg.
module qrm_output (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  qrm_pkg::div_t             in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [qrm_pkg::OUT_W-1:0] out_data,
    output logic                      out_degen
);

    localparam int EW = qrm_pkg::ELEM_W;

    logic                      valid_reg;
    logic [qrm_pkg::OUT_W-1:0] data_reg, data_next;
    logic                      degen_reg;

    always_comb
    begin
        logic [qrm_pkg::QUO_W-1:0] q;
        logic [EW-1:0]             m;
        for (int i = 0; i < qrm_pkg::NUM_ELEM; i++)
        begin
            q = (in_data.quo[i] > qrm_pkg::QUO_ONE) ? qrm_pkg::QUO_ONE : in_data.quo[i];
            m = in_data.neg[i] ? EW'(-{1'b0, q}) : EW'({1'b0, q});
            if (in_data.degen)
            begin
                m = (i % 4 == 0) ? qrm_pkg::ELEM_ONE : '0;
            end
            data_next[i*EW +: EW] = m;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_degen = degen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg  <= data_next;
            degen_reg <= in_data.degen;
        end
    end

endmodule

### rtl/quaternion_to_rotation_matrix.sv
// Takes one quaternion per item and gives the nine elements of its normalized rotation
// matrix in signed Q1.14, truncated toward zero. The block accepts one item every clock
// cycle when not stalled. Each item passes through one stage of ten multipliers,
// one stage forming the squared norm and the numerators, fifteen restoring-division stages
// that each settle one quotient bit of all nine elements, and the output register. Every
// stage holds its item while the stage after it is full, so tready low on the output only
// stops the input once the pipeline has no bubble left. A zero quaternion gives the
// identity matrix with tuser set.
// Depends on qrm_pkg and the qrm_* stage modules.
module quaternion_to_rotation_matrix (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [qrm_pkg::IN_W-1:0]  s_axis_tdata,  // quat_w, quat_x, quat_y, quat_z
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [qrm_pkg::OUT_W-1:0] m_axis_tdata,  // m00 m01 m02 m10 m11 m12 m20 m21 m22
    output logic [0:0]                m_axis_tuser   // degenerate
);

    localparam int NS = qrm_pkg::QUO_W;

    qrm_pkg::prod_t prod_data;
    logic           prod_valid, prod_ready;
    qrm_pkg::div_t  div_data  [NS+1];
    logic           div_valid [NS+1];
    logic           div_ready [NS+1];

    qrm_products u_products (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_data  (prod_data)
    );

    qrm_numer u_numer (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_data   (prod_data),
        .out_valid (div_valid[0]),
        .out_ready (div_ready[0]),
        .out_data  (div_data[0])
    );

    for (genvar k = 0; k < NS; k++)
    begin : g_div
        qrm_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (div_valid[k]),
            .in_ready  (div_ready[k]),
            .in_data   (div_data[k]),
            .out_valid (div_valid[k+1]),
            .out_ready (div_ready[k+1]),
            .out_data  (div_data[k+1])
        );
    end

    qrm_output u_output (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid[NS]),
        .in_ready  (div_ready[NS]),
        .in_data   (div_data[NS]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_degen (m_axis_tuser[0])
    );

endmodule

### rtl/qrm_checker.sv
// Port-level checks for the quaternion to rotation matrix block, bound to the top level.
// Depends on qrm_pkg and quaternion_to_rotation_matrix.
module qrm_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    input  logic                      s_axis_tready,
    input  logic [qrm_pkg::IN_W-1:0]  s_axis_tdata,
    input  logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    input  logic [qrm_pkg::OUT_W-1:0] m_axis_tdata,
    input  logic [0:0]                m_axis_tuser
);

    localparam int EW = qrm_pkg::ELEM_W;
    localparam logic signed [EW-1:0] POS1 = qrm_pkg::ELEM_ONE;
    localparam logic signed [EW-1:0] NEG1 = -qrm_pkg::ELEM_ONE;

    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("output valid during reset");

    // An offered input item stays in place until the block takes it.
    a_input_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
        else $error("offered input item changed before it was taken");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled output item changed");

    a_identity: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            m_axis_tdata[0*EW +: EW] == qrm_pkg::ELEM_ONE &&
            m_axis_tdata[4*EW +: EW] == qrm_pkg::ELEM_ONE &&
            m_axis_tdata[8*EW +: EW] == qrm_pkg::ELEM_ONE &&
            m_axis_tdata[1*EW +: EW] == '0 && m_axis_tdata[5*EW +: EW] == '0)
        else $error("zero quaternion did not give the identity");

    a_diag_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            $signed(m_axis_tdata[0*EW +: EW]) <= POS1 &&
            $signed(m_axis_tdata[0*EW +: EW]) >= NEG1 &&
            $signed(m_axis_tdata[4*EW +: EW]) <= POS1 &&
            $signed(m_axis_tdata[4*EW +: EW]) >= NEG1 &&
            $signed(m_axis_tdata[8*EW +: EW]) <= POS1 &&
            $signed(m_axis_tdata[8*EW +: EW]) >= NEG1)
        else $error("diagonal element beyond one");

endmodule

bind quaternion_to_rotation_matrix qrm_checker u_qrm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### bench/tb_quaternion_to_rotation_matrix.sv
// Self-checking bench for quaternion_to_rotation_matrix: directed quaternions, then random ones,
// with random stalls on both streams. Expected matrices come from an exact integer predictor.
// Depends on qrm_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_quaternion_to_rotation_matrix;

    localparam int N_DIRECTED = 16;
    localparam int N_RANDOM   = 1200;
    localparam longint CYCLE_LIMIT = 400000;
    localparam int NUMW = qrm_pkg::DEN_W + 1;
    localparam int QW   = qrm_pkg::DEN_W + qrm_pkg::FRAC_W + 2;

    typedef struct packed {
        logic [qrm_pkg::NUM_ELEM-1:0][qrm_pkg::ELEM_W-1:0] elem;   // elem[0] is m00
        logic                                              degen;
    } matrix_t;

    typedef struct {
        logic [qrm_pkg::COMP_W-1:0] w, x, y, z;
        bit                         typed;      // expected value given in the row
        matrix_t                    mat;
    } quat_row_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [qrm_pkg::IN_W-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [qrm_pkg::OUT_W-1:0] m_axis_tdata;
    logic [0:0] m_axis_tuser;

    quaternion_to_rotation_matrix dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    matrix_t   pending_matrices[$];
    quat_row_t directed_rows[N_DIRECTED];
    int        mismatches;
    longint    cycles;
    bit        long_hold;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Exact quotient num/den in Q1.FRAC_W, truncated toward zero and saturated.
    function automatic logic [qrm_pkg::ELEM_W-1:0] scaled_quotient(logic [NUMW-1:0] num,
                                                                   bit neg,
                                                                   logic [NUMW-1:0] den);
        logic [QW-1:0] q;
        q = ({{(qrm_pkg::FRAC_W+1){1'b0}}, num} << qrm_pkg::FRAC_W) / QW'(den);
        if (q > QW'(qrm_pkg::QUO_ONE))
            q = QW'(qrm_pkg::QUO_ONE);
        if (neg)
            q = -q;
        return q[qrm_pkg::ELEM_W-1:0];
    endfunction

    function automatic logic [qrm_pkg::ELEM_W-1:0] cross_term(longint p, longint q,
                                                              logic [NUMW-1:0] den);
        longint s;
        logic [NUMW-1:0] mag;
        s = p + q;
        mag = NUMW'(s < 0 ? -s : s);
        return scaled_quotient(mag << 1, s < 0, den);
    endfunction

    function automatic logic [qrm_pkg::ELEM_W-1:0] diag_term(longint pos, longint negp,
                                                             logic [NUMW-1:0] den);
        longint d;
        d = pos - negp;
        return scaled_quotient(NUMW'(d < 0 ? -d : d), d < 0, den);
    endfunction

    function automatic matrix_t rotation_of(logic [qrm_pkg::COMP_W-1:0] qw,
                                            logic [qrm_pkg::COMP_W-1:0] qx,
                                            logic [qrm_pkg::COMP_W-1:0] qy,
                                            logic [qrm_pkg::COMP_W-1:0] qz);
        longint w, x, y, z, ww, xx, yy, zz;
        logic [NUMW-1:0] n;
        matrix_t m;
        w = longint'($signed(qw));
        x = longint'($signed(qx));
        y = longint'($signed(qy));
        z = longint'($signed(qz));
        ww = w * w;
        xx = x * x;
        yy = y * y;
        zz = z * z;
        n = NUMW'(ww + xx + yy + zz);
        m = '0;
        if (n == 0)
        begin
            m.elem[0] = qrm_pkg::ELEM_ONE;
            m.elem[4] = qrm_pkg::ELEM_ONE;
            m.elem[8] = qrm_pkg::ELEM_ONE;
            m.degen   = 1'b1;
            return m;
        end
        m.elem[0] = diag_term(ww + xx, yy + zz, n);
        m.elem[1] = cross_term(x * y, -(w * z), n);
        m.elem[2] = cross_term(x * z, w * y, n);
        m.elem[3] = cross_term(x * y, w * z, n);
        m.elem[4] = diag_term(ww + yy, xx + zz, n);
        m.elem[5] = cross_term(y * z, -(w * x), n);
        m.elem[6] = cross_term(x * z, -(w * y), n);
        m.elem[7] = cross_term(y * z, w * x, n);
        m.elem[8] = diag_term(ww + zz, xx + yy, n);
        return m;
    endfunction

    function automatic quat_row_t make_row(int w, int x, int y, int z);
        quat_row_t r;
        r.w = w[qrm_pkg::COMP_W-1:0];
        r.x = x[qrm_pkg::COMP_W-1:0];
        r.y = y[qrm_pkg::COMP_W-1:0];
        r.z = z[qrm_pkg::COMP_W-1:0];
        r.typed = 1'b0;
        r.mat = '0;
        return r;
    endfunction

    function automatic matrix_t diag_matrix(int d0, int d1, int d2);
        matrix_t m;
        m = '0;
        m.elem[0] = d0[qrm_pkg::ELEM_W-1:0];
        m.elem[4] = d1[qrm_pkg::ELEM_W-1:0];
        m.elem[8] = d2[qrm_pkg::ELEM_W-1:0];
        return m;
    endfunction

    function automatic logic [qrm_pkg::COMP_W-1:0] random_component();
        case ($urandom_range(0, 7))
            0: return qrm_pkg::COMP_W'(16'h8000);
            1: return qrm_pkg::COMP_W'(16'h7fff);
            2: return qrm_pkg::COMP_W'($urandom_range(0, 15));
            3: return -qrm_pkg::COMP_W'($urandom_range(0, 15));
            4: return qrm_pkg::COMP_W'($urandom_range(0, 255) - 128);
            default: return qrm_pkg::COMP_W'($urandom);
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    // The valid line is only dropped when an idle gap follows.
    task automatic send_quaternion(logic [qrm_pkg::COMP_W-1:0] w,
                                   logic [qrm_pkg::COMP_W-1:0] x,
                                   logic [qrm_pkg::COMP_W-1:0] y,
                                   logic [qrm_pkg::COMP_W-1:0] z);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {z, y, x, w};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Expected matrices are queued when the input item is taken, on the same edge.
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            pending_matrices.push_back(rotation_of(s_axis_tdata[0 +: qrm_pkg::COMP_W],
                s_axis_tdata[qrm_pkg::COMP_W +: qrm_pkg::COMP_W],
                s_axis_tdata[2*qrm_pkg::COMP_W +: qrm_pkg::COMP_W],
                s_axis_tdata[3*qrm_pkg::COMP_W +: qrm_pkg::COMP_W]));
    end

    always @(posedge clk)
    begin
        matrix_t want;
        matrix_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.elem  = m_axis_tdata;
            got.degen = m_axis_tuser[0];
            if (pending_matrices.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output item %h", got);
            end
            else
            begin
                want = pending_matrices.pop_front();
                for (int k = 0; k < qrm_pkg::NUM_ELEM; k++)
                begin
                    if (got.elem[k] !== want.elem[k])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("m%0d%0d: expected %h, got %h", k / 3, k % 3,
                                     want.elem[k], got.elem[k]);
                    end
                end
                if (got.degen !== want.degen)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("degenerate: expected %b, got %b", want.degen, got.degen);
                end
            end
        end
    end

    // Receiver: random stalls, with one long hold so the pipeline backs up.
    initial
    begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                m_axis_tready <= 1'b0;
                repeat (200) @(negedge clk);
                long_hold = 1'b0;
            end
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
            if (gap != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        matrix_t want;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        mismatches = 0;
        long_hold = 1'b0;

        // Zero quaternion, single-axis quaternions at the extremes, and mixed cases.
        directed_rows[0]  = make_row(0, 0, 0, 0);
        directed_rows[0].typed = 1'b1;
        directed_rows[0].mat = diag_matrix(16384, 16384, 16384);
        directed_rows[0].mat.degen = 1'b1;
        directed_rows[1]  = make_row(32767, 0, 0, 0);
        directed_rows[1].typed = 1'b1;
        directed_rows[1].mat = diag_matrix(16384, 16384, 16384);
        directed_rows[2]  = make_row(-32768, 0, 0, 0);
        directed_rows[2].typed = 1'b1;
        directed_rows[2].mat = diag_matrix(16384, 16384, 16384);
        directed_rows[3]  = make_row(0, -32768, 0, 0);
        directed_rows[3].typed = 1'b1;
        directed_rows[3].mat = diag_matrix(16384, -16384, -16384);
        directed_rows[4]  = make_row(0, 0, 32767, 0);
        directed_rows[4].typed = 1'b1;
        directed_rows[4].mat = diag_matrix(-16384, 16384, -16384);
        directed_rows[5]  = make_row(0, 0, 0, -32768);
        directed_rows[5].typed = 1'b1;
        directed_rows[5].mat = diag_matrix(-16384, -16384, 16384);
        directed_rows[6]  = make_row(-32768, -32768, -32768, -32768);
        directed_rows[7]  = make_row(32767, 32767, 32767, 32767);
        directed_rows[8]  = make_row(32767, -32768, 32767, -32768);
        directed_rows[9]  = make_row(1, 1, 1, 1);
        directed_rows[10] = make_row(-1, 0, 0, 1);
        directed_rows[11] = make_row(1, 1, 0, 0);
        directed_rows[12] = make_row(3, -5, 7, -11);
        directed_rows[13] = make_row(0, 1, 1, 1);
        directed_rows[14] = make_row(-32768, 32767, 1, -1);
        directed_rows[15] = make_row(23170, 0, 23170, 0);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Rows with a typed expectation are checked against the predictor first.
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].typed)
            begin
                want = rotation_of(directed_rows[i].w, directed_rows[i].x,
                                   directed_rows[i].y, directed_rows[i].z);
                if (want !== directed_rows[i].mat)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("row %0d: expected %h, predicted %h", i,
                                 directed_rows[i].mat, want);
                end
            end
            send_quaternion(directed_rows[i].w, directed_rows[i].x,
                            directed_rows[i].y, directed_rows[i].z);
        end

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM / 3)
                long_hold = 1'b1;
            send_quaternion(random_component(), random_component(),
                            random_component(), random_component());
        end
        s_axis_tvalid <= 1'b0;

        while (pending_matrices.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
